// File: rtl/cbe_pkg.sv
package cbe_pkg;

  // Fixed-point formats at the ports and inside the datapath
  localparam int PortFracBits  = 16;
  localparam int InnerFracBits = 24;
  localparam int FracShift     = InnerFracBits - PortFracBits;
  localparam int MaxIterations = 10;

  // Field widths
  localparam int XWidth = 17;
  localparam int YWidth = 19;

  // 1e-6 in the inner format, rounded to nearest, at least one
  localparam int TolRaw = ((1 << InnerFracBits) + 500000) / 1000000;
  localparam int Tol    = (TolRaw < 1) ? 1 : TolRaw;

  // Output saturation bounds in the port format
  localparam int YLow  = -2 * (1 << PortFracBits);
  localparam int YHigh = 3 * (1 << PortFracBits);

  // Register indexes
  localparam logic [1:0] RegX1 = 2'd0;
  localparam logic [1:0] RegY1 = 2'd1;
  localparam logic [1:0] RegX2 = 2'd2;
  localparam logic [1:0] RegY2 = 2'd3;

  // Value in [0,1] in the inner format
  typedef logic [InnerFracBits:0] unit_t;
  // Multiplier operand, signed, wide enough for a y control point
  typedef logic signed [InnerFracBits+3:0] opnd_t;
  // Accumulator for curve sums and derivative sums
  typedef logic signed [InnerFracBits+7:0] acc_t;

  localparam unit_t OneInner = unit_t'(1 << InnerFracBits);

endpackage

// File: rtl/cubic_bezier_easing_top.sv
// Cubic Bezier easing evaluator.
// Control points (x1,y1) and (x2,y2) are written over the APB port: x1 at
// 0x0, y1 at 0x4, x2 at 0x8, y2 at 0xC; x values Q16 unsigned, y values
// Q16 signed. Write them only while no item is in flight.
// Each progress value x (Q16, s_axis_tdata[16:0]) is solved for Bx(t) = x by
// Newton steps starting at t = x, then By(t) is returned on m_axis_tdata
// (Q16 signed, 19 bits) with the converged flag on m_axis_tuser.
// One shared 27x27 multiplier computes all products; a Newton step uses
// 11 products, a check state and a restoring divider with a compare state
// and 25 quotient steps (skipped when the quotient saturates), then an
// update state. The closing pass takes 8 products. An item takes up to
// MAX_ITERATIONS Newton steps.
// The block takes one item at a time; s_axis_tready is high only while idle.
// The result sits in an output register, so a new item is accepted while it
// waits; a stalled receiver holds the next result in the closing state.
// Reset clears the control points to (0,0) and (1,1) and drops any result.
module cubic_bezier_easing_top #(
  parameter int MAX_ITERATIONS = cbe_pkg::MaxIterations
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [16:0] progress_in
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [18:0] eased_out
  output logic        m_axis_tuser    // [0] converged
);

  localparam int IterW = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;
  localparam int Ifb   = cbe_pkg::InnerFracBits;
  localparam int Sh    = cbe_pkg::FracShift;
  localparam int XW    = cbe_pkg::XWidth;
  localparam int YW    = cbe_pkg::YWidth;
  localparam int AccW  = $bits(cbe_pkg::acc_t);
  localparam int MagW  = $bits(cbe_pkg::opnd_t) - 1;
  localparam int ProdW = 2 * MagW;
  localparam int QuoW  = Ifb + 2;
  localparam int CntW  = $clog2(Ifb + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ISSUE, S_WB, S_CHECK, S_DIV_CMP, S_DIV, S_UPDATE, S_YOUT
  } state_e;

  typedef enum logic [3:0] {
    OpUu, OpTt, OpUt, OpA, OpB, OpC, OpF1, OpF2, OpD1, OpD2, OpD3, OpY1, OpY2
  } op_e;

  state_e state_q;
  op_e    op_q;

  logic [XW-1:0] ctrl_x1_q, ctrl_x2_q;
  logic [YW-1:0] ctrl_y1_q, ctrl_y2_q;

  cbe_pkg::unit_t t_q, x_q, uu_q, tt_q, ut_q, a_q, b_q, c_q;
  cbe_pkg::acc_t  acc_q, dacc_q;
  logic [ProdW-1:0] prod_q;
  logic             pneg_q;
  logic [AccW-1:0]  rem_q;
  logic [QuoW-1:0]  quo_q;
  logic [CntW-1:0]  dcnt_q;
  logic             dneg_q;
  logic [IterW-1:0] iter_q;
  logic             final_q, conv_q;

  logic          out_valid_q, out_conv_q;
  logic [YW-1:0] out_y_q;

  // ---------------------------------------------------------------------
  // Configuration port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[3:2])
      cbe_pkg::RegX1: prdata = 32'(ctrl_x1_q);
      cbe_pkg::RegY1: prdata = 32'(ctrl_y1_q);
      cbe_pkg::RegX2: prdata = 32'(ctrl_x2_q);
      cbe_pkg::RegY2: prdata = 32'(ctrl_y2_q);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Port to inner conversion
  function automatic cbe_pkg::unit_t port_x(logic [XW-1:0] raw);
    logic [XW-1:0] lim;
    logic [XW-1:0] v;
    lim = XW'(1 << cbe_pkg::PortFracBits);
    v   = (raw > lim) ? lim : raw;
    return cbe_pkg::unit_t'({v, {Sh{1'b0}}});
  endfunction

  function automatic cbe_pkg::opnd_t port_y(logic [YW-1:0] raw);
    return cbe_pkg::opnd_t'($signed({raw, {Sh{1'b0}}}));
  endfunction

  function automatic cbe_pkg::opnd_t from_unit(cbe_pkg::unit_t v);
    return cbe_pkg::opnd_t'($signed({1'b0, v}));
  endfunction

  cbe_pkg::unit_t x1_in, x2_in, u;
  cbe_pkg::opnd_t y1_in, y2_in;

  assign x1_in = port_x(ctrl_x1_q);
  assign x2_in = port_x(ctrl_x2_q);
  assign y1_in = port_y(ctrl_y1_q);
  assign y2_in = port_y(ctrl_y2_q);
  assign u     = cbe_pkg::OneInner - t_q;

  // ---------------------------------------------------------------------
  // Shared multiplier: operand select, magnitudes, rounded signed result
  cbe_pkg::opnd_t opa, opb;

  always_comb begin
    opa = from_unit(u);
    opb = from_unit(u);
    unique case (op_q)
      OpUu: begin opa = from_unit(u);    opb = from_unit(u);    end
      OpTt: begin opa = from_unit(t_q);  opb = from_unit(t_q);  end
      OpUt: begin opa = from_unit(u);    opb = from_unit(t_q);  end
      OpA:  begin opa = from_unit(uu_q); opb = from_unit(t_q);  end
      OpB:  begin opa = from_unit(u);    opb = from_unit(tt_q); end
      OpC:  begin opa = from_unit(tt_q); opb = from_unit(t_q);  end
      OpF1: begin opa = from_unit(a_q);  opb = from_unit(x1_in); end
      OpF2: begin opa = from_unit(b_q);  opb = from_unit(x2_in); end
      OpD1: begin opa = from_unit(uu_q); opb = from_unit(x1_in); end
      OpD2: begin
        opa = from_unit(ut_q);
        opb = from_unit(x2_in) - from_unit(x1_in);
      end
      OpD3: begin
        opa = from_unit(tt_q);
        opb = from_unit(cbe_pkg::OneInner - x2_in);
      end
      OpY1: begin opa = from_unit(a_q);  opb = y1_in; end
      OpY2: begin opa = from_unit(b_q);  opb = y2_in; end
      default: begin opa = from_unit(u); opb = from_unit(u); end
    endcase
  end

  logic [MagW-1:0] mag_a, mag_b;
  assign mag_a = opa[MagW] ? MagW'(-opa) : MagW'(opa);
  assign mag_b = opb[MagW] ? MagW'(-opb) : MagW'(opb);

  // round to nearest, ties away from zero, on the magnitude
  logic [ProdW-1:0] prod_rnd;
  logic [MagW-1:0]  rnd_mag;
  cbe_pkg::opnd_t   mres;
  cbe_pkg::acc_t    mx, m3;
  assign prod_rnd = prod_q + ProdW'(1 << (Ifb - 1));
  assign rnd_mag  = prod_rnd[Ifb +: MagW];
  assign mres     = pneg_q ? -cbe_pkg::opnd_t'({1'b0, rnd_mag})
                           :  cbe_pkg::opnd_t'({1'b0, rnd_mag});
  assign mx       = cbe_pkg::acc_t'(mres);
  assign m3       = mx + (mx <<< 1);

  // ---------------------------------------------------------------------
  // Divider and update datapath
  logic [AccW-1:0] f_mag, df_mag, div_shift;
  logic            div_ge;
  assign f_mag     = acc_q[AccW-1] ? AccW'(-acc_q) : AccW'(acc_q);
  assign df_mag    = dacc_q[AccW-1] ? AccW'(-dacc_q) : AccW'(dacc_q);
  assign div_shift = (dcnt_q == '0) ? rem_q : (rem_q << 1);
  assign div_ge    = div_shift >= df_mag;

  localparam int TW = Ifb + 4;
  logic signed [TW-1:0] q_s, t_new;
  assign q_s   = $signed({2'b00, quo_q});
  assign t_new = $signed({3'b000, t_q}) - (dneg_q ? -q_s : q_s);

  cbe_pkg::unit_t t_clamped;
  always_comb begin
    priority if (t_new < 0) begin
      t_clamped = '0;
    end else if (t_new > $signed({3'b000, cbe_pkg::OneInner})) begin
      t_clamped = cbe_pkg::OneInner;
    end else begin
      t_clamped = t_new[Ifb:0];
    end
  end

  // Inner to port conversion with saturation
  logic [AccW-1:0]    y_mag;
  cbe_pkg::acc_t      y_s;
  logic [YW-1:0]      y_sat;
  assign y_mag = (f_mag + AccW'(1 << (Sh - 1))) >> Sh;
  assign y_s   = acc_q[AccW-1] ? -$signed(y_mag) : $signed(y_mag);

  always_comb begin
    priority if (y_s < cbe_pkg::acc_t'(cbe_pkg::YLow)) begin
      y_sat = YW'(cbe_pkg::YLow);
    end else if (y_s > cbe_pkg::acc_t'(cbe_pkg::YHigh)) begin
      y_sat = YW'(cbe_pkg::YHigh);
    end else begin
      y_sat = y_s[YW-1:0];
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = 24'(out_y_q);
  assign m_axis_tuser  = out_conv_q;

  logic last_iter;
  assign last_iter = (iter_q == IterW'(MAX_ITERATIONS - 1));

  // ---------------------------------------------------------------------
  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OpUu;
      iter_q      <= '0;
      final_q     <= 1'b0;
      conv_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_y_q     <= '0;
      out_conv_q  <= 1'b0;
      x_q         <= '0;
      t_q         <= '0;
      uu_q        <= '0;
      tt_q        <= '0;
      ut_q        <= '0;
      a_q         <= '0;
      b_q         <= '0;
      c_q         <= '0;
      acc_q       <= '0;
      dacc_q      <= '0;
      prod_q      <= '0;
      pneg_q      <= 1'b0;
      rem_q       <= '0;
      quo_q       <= '0;
      dcnt_q      <= '0;
      dneg_q      <= 1'b0;
      ctrl_x1_q   <= '0;
      ctrl_y1_q   <= '0;
      ctrl_x2_q   <= XW'(1 << cbe_pkg::PortFracBits);
      ctrl_y2_q   <= YW'(1 << cbe_pkg::PortFracBits);
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          cbe_pkg::RegX1: ctrl_x1_q <= pwdata[XW-1:0];
          cbe_pkg::RegY1: ctrl_y1_q <= pwdata[YW-1:0];
          cbe_pkg::RegX2: ctrl_x2_q <= pwdata[XW-1:0];
          cbe_pkg::RegY2: ctrl_y2_q <= pwdata[YW-1:0];
          default: ;
        endcase
      end

      // drop a taken result; the closing state reloads the register itself
      if (out_valid_q && m_axis_tready && state_q != S_YOUT) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            x_q     <= port_x(s_axis_tdata[XW-1:0]);
            t_q     <= port_x(s_axis_tdata[XW-1:0]);
            iter_q  <= '0;
            final_q <= 1'b0;
            conv_q  <= 1'b0;
            op_q    <= OpUu;
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          prod_q  <= ProdW'(mag_a) * ProdW'(mag_b);
          pneg_q  <= opa[MagW] ^ opb[MagW];
          state_q <= S_WB;
        end
        S_WB: begin
          unique case (op_q)
            OpUu: uu_q <= mres[Ifb:0];
            OpTt: tt_q <= mres[Ifb:0];
            OpUt: ut_q <= mres[Ifb:0];
            OpA:  a_q  <= mres[Ifb:0];
            OpB:  b_q  <= mres[Ifb:0];
            OpC:  c_q  <= mres[Ifb:0];
            OpF1: acc_q <= m3 + cbe_pkg::acc_t'($signed({1'b0, c_q}))
                              - cbe_pkg::acc_t'($signed({1'b0, x_q}));
            OpF2: acc_q  <= acc_q + m3;
            OpD1: dacc_q <= m3;
            OpD2: dacc_q <= dacc_q + (m3 <<< 1);
            OpD3: dacc_q <= dacc_q + m3;
            OpY1: acc_q  <= m3 + cbe_pkg::acc_t'($signed({1'b0, c_q}));
            OpY2: acc_q  <= acc_q + m3;
            default: ;
          endcase
          priority if (final_q && op_q == OpC) begin
            op_q    <= OpY1;
            state_q <= S_ISSUE;
          end else if (final_q && op_q == OpY2) begin
            state_q <= S_YOUT;
          end else if (!final_q && op_q == OpD3) begin
            state_q <= S_CHECK;
          end else begin
            op_q    <= op_e'(op_q + 4'd1);
            state_q <= S_ISSUE;
          end
        end
        S_CHECK: begin
          // tolerance first, so a zero f with a zero df still converges
          priority if (f_mag < AccW'(cbe_pkg::Tol)) begin
            conv_q  <= 1'b1;
            final_q <= 1'b1;
            op_q    <= OpUu;
            state_q <= S_ISSUE;
          end else if (dacc_q == '0) begin
            final_q <= 1'b1;
            op_q    <= OpUu;
            state_q <= S_ISSUE;
          end else begin
            state_q <= S_DIV_CMP;
          end
        end
        S_DIV_CMP: begin
          dneg_q <= acc_q[AccW-1] ^ dacc_q[AccW-1];
          // a quotient of two or more saturates at two
          if ({1'b0, f_mag} >= {df_mag, 1'b0}) begin
            quo_q   <= QuoW'(2 << Ifb);
            state_q <= S_UPDATE;
          end else begin
            rem_q   <= f_mag;
            quo_q   <= '0;
            dcnt_q  <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q <= div_ge ? (div_shift - df_mag) : div_shift;
          quo_q <= {quo_q[QuoW-2:0], div_ge};
          if (dcnt_q == CntW'(Ifb)) begin
            state_q <= S_UPDATE;
          end else begin
            dcnt_q <= dcnt_q + 1'b1;
          end
        end
        S_UPDATE: begin
          t_q  <= t_clamped;
          op_q <= OpUu;
          if (last_iter) begin
            final_q <= 1'b1;
          end else begin
            iter_q <= iter_q + 1'b1;
          end
          state_q <= S_ISSUE;
        end
        S_YOUT: begin
          // hold while the previous result is still waiting
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_y_q     <= y_sat;
            out_conv_q  <= conv_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
